>>> hw/rtl/mcls_pkg.sv
// ----------------------------------------------------------------------------
// mcls_pkg
// Types and constants shared by the loop sampler top level, front end and back end.
// ----------------------------------------------------------------------------
package mcls_pkg;

  localparam int SAMPLE_W = 24;
  localparam int LEN_W    = 19;
  localparam int NOTE_W   = 7;
  localparam int EVT_W    = 5;

  localparam logic [3:0] MIDI_NOTE_ON = 4'h9;

  localparam logic [LEN_W-1:0]  LEN_RST       = 19'd262144;
  localparam logic [NOTE_W-1:0] TRANSPORT_RST = 7'd48;
  localparam logic [NOTE_W-1:0] RECORD_RST    = 7'd49;
  localparam logic [NOTE_W-1:0] PLAY_RST      = 7'd50;
  localparam logic [NOTE_W-1:0] ERASE_RST     = 7'd51;
  localparam logic [NOTE_W-1:0] BYPASS_RST    = 7'd52;

  // pending event bit positions
  localparam int EVT_TRANSPORT = 0;
  localparam int EVT_RECORD    = 1;
  localparam int EVT_PLAY      = 2;
  localparam int EVT_ERASE     = 3;
  localparam int EVT_BYPASS    = 4;

  typedef enum logic [2:0] {
    REG_LOOP_LENGTH    = 3'd0,
    REG_SYNC_TO_HOST   = 3'd1,
    REG_TRANSPORT_NOTE = 3'd2,
    REG_RECORD_NOTE    = 3'd3,
    REG_PLAY_NOTE      = 3'd4,
    REG_ERASE_NOTE     = 3'd5,
    REG_BYPASS_NOTE    = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_RECORD = 3'd1,
    MODE_PLAY   = 3'd2,
    MODE_ERASE  = 3'd3,
    MODE_BYPASS = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    OP_MIDI,
    OP_PASS,
    OP_RECORD,
    OP_PLAY,
    OP_ERASE
  } op_t;

  typedef enum logic [1:0] {
    F_RUN,
    F_LOAD,
    F_MOD
  } fstate_t;

  typedef struct packed {
    logic                       cmd;
    logic [7:0]                 status_byte;
    logic [7:0]                 note_byte;
    logic [7:0]                 velocity_byte;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       host_playing;
  } in_item_t;

  typedef struct packed {
    logic                       kind;
    logic [7:0]                 midi_status;
    logic [7:0]                 midi_data1;
    logic [7:0]                 midi_data2;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_item_t;

  // work item handed from front end to back end
  typedef struct packed {
    op_t                        op;
    logic [7:0]                 status;
    logic [7:0]                 data1;
    logic [7:0]                 data2;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } q_item_t;

  typedef struct packed {
    logic              sync_to_host;
    logic [NOTE_W-1:0] transport_note;
    logic [NOTE_W-1:0] record_note;
    logic [NOTE_W-1:0] play_note;
    logic [NOTE_W-1:0] erase_note;
    logic [NOTE_W-1:0] bypass_note;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } bk_status_t;

endpackage

>>> hw/rtl/mcls_fifo.sv
// ----------------------------------------------------------------------------
// mcls_fifo
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mcls_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  logic [W-1:0] buf_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue push while full");

endmodule

>>> hw/rtl/mcls_front.sv
// ----------------------------------------------------------------------------
// mcls_front
// Takes input transactions, collects note-on events, resolves mode, free-run
// and loop position, and queues one work item per transaction. Also reduces
// the position after a loop length change, one bit per cycle.
// ----------------------------------------------------------------------------
module mcls_front #(
  parameter int AW = 18,
  parameter int LW = 19
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcls_pkg::in_item_t  in_data,
  input  mcls_pkg::cfg_t      cfg,
  input  logic [LW-1:0]       eff_len,
  input  logic                len_wr,
  input  logic                q_full,
  input  mcls_pkg::bk_status_t bk,
  output logic                q_push,
  output mcls_pkg::q_item_t   q_item,
  output logic [AW-1:0]       q_addr
);

  localparam int CW = (AW > 1) ? $clog2(AW) : 1;

  mcls_pkg::fstate_t state_r, state_nxt;
  logic [mcls_pkg::EVT_W-1:0] pend_r, pend_nxt;
  mcls_pkg::mode_t mode_r, mode_nxt;
  logic            free_r, free_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic [LW-1:0]   rem_r, rem_nxt;
  logic [LW-1:0]   div_r, div_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            again_r, again_nxt;

  logic                       accept;
  logic                       mod_last;
  logic [mcls_pkg::EVT_W-1:0] hit;
  logic [mcls_pkg::EVT_W-1:0] evt;
  mcls_pkg::mode_t            mode_upd;
  logic                       free_upd;
  logic                       adv;
  logic [AW:0]                pos_inc;
  logic [AW-1:0]              pos_wrap;
  logic [LW-1:0]              trial;
  logic [LW-1:0]              trial_sub;
  logic                       run_en;

  assign accept   = in_valid && in_ready;
  assign mod_last = (cnt_r == CW'(AW - 1));

  // ---- state machine ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mcls_pkg::F_RUN:  if (len_wr) state_nxt = mcls_pkg::F_LOAD;
      mcls_pkg::F_LOAD: state_nxt = mcls_pkg::F_MOD;
      mcls_pkg::F_MOD: begin
        if (mod_last) state_nxt = (again_r || len_wr) ? mcls_pkg::F_LOAD : mcls_pkg::F_RUN;
      end
      default: state_nxt = mcls_pkg::F_RUN;
    endcase
  end

  always_comb begin
    run_en = 1'b0;
    unique case (state_r)
      mcls_pkg::F_RUN: run_en = 1'b1;
      default:         run_en = 1'b0;
    endcase
    in_ready = run_en && !q_full && !bk.clearing;
  end

  // ---- event collection and mode resolution ----
  always_comb begin
    hit = '0;
    if (in_data.status_byte[7:4] == mcls_pkg::MIDI_NOTE_ON) begin
      hit[mcls_pkg::EVT_TRANSPORT] = (in_data.note_byte == {1'b0, cfg.transport_note});
      hit[mcls_pkg::EVT_RECORD]    = (in_data.note_byte == {1'b0, cfg.record_note});
      hit[mcls_pkg::EVT_PLAY]      = (in_data.note_byte == {1'b0, cfg.play_note});
      hit[mcls_pkg::EVT_ERASE]     = (in_data.note_byte == {1'b0, cfg.erase_note});
      hit[mcls_pkg::EVT_BYPASS]    = (in_data.note_byte == {1'b0, cfg.bypass_note});
    end
  end

  always_comb begin
    evt      = pend_r;
    free_upd = free_r ^ evt[mcls_pkg::EVT_TRANSPORT];
    if (evt[mcls_pkg::EVT_BYPASS])      mode_upd = mcls_pkg::MODE_BYPASS;
    else if (evt[mcls_pkg::EVT_ERASE])  mode_upd = mcls_pkg::MODE_ERASE;
    else if (evt[mcls_pkg::EVT_PLAY])   mode_upd = mcls_pkg::MODE_PLAY;
    else if (evt[mcls_pkg::EVT_RECORD]) mode_upd = mcls_pkg::MODE_RECORD;
    else                                mode_upd = mode_r;
    adv      = (cfg.sync_to_host && in_data.host_playing) || free_upd;
    pos_inc  = {1'b0, pos_r} + {{AW{1'b0}}, adv};
    pos_wrap = (LW'(pos_inc) >= eff_len) ? '0 : pos_inc[AW-1:0];
  end

  // ---- queued work item ----
  always_comb begin
    q_push = accept;
    q_addr = pos_r;
    q_item = '0;
    if (!in_data.cmd) begin
      q_item.op     = mcls_pkg::OP_MIDI;
      q_item.status = in_data.status_byte;
      q_item.data1  = in_data.note_byte;
      q_item.data2  = in_data.velocity_byte;
    end else begin
      q_item.left  = in_data.left_in;
      q_item.right = in_data.right_in;
      unique case (mode_upd)
        mcls_pkg::MODE_RECORD: q_item.op = mcls_pkg::OP_RECORD;
        mcls_pkg::MODE_PLAY:   q_item.op = mcls_pkg::OP_PLAY;
        mcls_pkg::MODE_ERASE:  q_item.op = mcls_pkg::OP_ERASE;
        default:               q_item.op = mcls_pkg::OP_PASS;
      endcase
    end
  end

  // ---- next state of registers ----
  always_comb begin
    pend_nxt  = pend_r;
    mode_nxt  = mode_r;
    free_nxt  = free_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    again_nxt = again_r;
    // restoring remainder step: shift in the next dividend bit
    trial     = {rem_r[LW-2:0], pos_r[AW-1]};
    trial_sub = (trial >= div_r) ? (trial - div_r) : trial;

    if (accept) begin
      if (!in_data.cmd) begin
        pend_nxt = pend_r | hit;
      end else begin
        pend_nxt = '0;
        mode_nxt = mode_upd;
        free_nxt = free_upd;
        pos_nxt  = pos_wrap;
      end
    end

    if (state_r == mcls_pkg::F_LOAD) begin
      again_nxt = 1'b0;
      div_nxt   = eff_len;
      rem_nxt   = '0;
      cnt_nxt   = '0;
    end
    if (state_r == mcls_pkg::F_MOD) begin
      rem_nxt = trial_sub;
      cnt_nxt = cnt_r + CW'(1);
      pos_nxt = mod_last ? trial_sub[AW-1:0] : {pos_r[AW-2:0], 1'b0};
    end
    if (len_wr && state_r != mcls_pkg::F_RUN) again_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcls_pkg::F_RUN;
      pend_r  <= '0;
      mode_r  <= mcls_pkg::MODE_IDLE;
      free_r  <= 1'b0;
      pos_r   <= '0;
      again_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      mode_r  <= mode_nxt;
      free_r  <= free_nxt;
      pos_r   <= pos_nxt;
      again_r <= again_nxt;
    end
  end

  a_pend_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.cmd) |=> (pend_r == '0))
    else $error("pending events not consumed by sample frame");

  a_pos_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcls_pkg::F_RUN) |-> (LW'(pos_r) < eff_len))
    else $error("position outside loop length");

endmodule

>>> hw/rtl/mcls_back.sv
// ----------------------------------------------------------------------------
// mcls_back
// Carries out queued work items on the loop memory and holds the result
// register. Clears the loop memory after reset, one word per cycle.
// ----------------------------------------------------------------------------
module mcls_back #(
  parameter int LOOP_DEPTH = 262144,
  parameter int AW         = 18
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  mcls_pkg::q_item_t    q_item,
  input  logic [AW-1:0]        q_addr,
  output logic                 q_pop,
  output mcls_pkg::bk_status_t bk,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mcls_pkg::out_item_t  out_data
);

  localparam int DW = 2 * mcls_pkg::SAMPLE_W;

  logic [DW-1:0] mem [LOOP_DEPTH];

  logic                clr_r, clr_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic                a_valid_r, a_valid_nxt;
  mcls_pkg::q_item_t   a_item_r;
  logic [DW-1:0]       rdata_r;
  logic                out_valid_r, out_valid_nxt;
  mcls_pkg::out_item_t out_data_r;
  mcls_pkg::out_item_t res;

  logic          out_load;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  assign out_load    = a_valid_r && (!out_valid_r || out_ready);
  assign q_pop       = !clr_r && !q_empty && (!a_valid_r || out_load);
  assign bk.clearing = clr_r;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = q_addr;
    wr_data = '0;
    if (clr_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
    end else if (q_pop) begin
      case (q_item.op)
        mcls_pkg::OP_RECORD: begin
          wr_en   = 1'b1;
          wr_data = {q_item.left, q_item.right};
        end
        mcls_pkg::OP_ERASE: wr_en = 1'b1;
        default:            wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (q_pop) begin
      rdata_r <= mem[q_addr];
    end
  end

  // result formation from the stage holding the memory read
  always_comb begin
    res = '0;
    case (a_item_r.op)
      mcls_pkg::OP_MIDI: begin
        res.midi_status = a_item_r.status;
        res.midi_data1  = a_item_r.data1;
        res.midi_data2  = a_item_r.data2;
      end
      mcls_pkg::OP_PLAY: begin
        res.kind      = 1'b1;
        res.left_out  = rdata_r[DW-1:mcls_pkg::SAMPLE_W];
        res.right_out = rdata_r[mcls_pkg::SAMPLE_W-1:0];
      end
      default: begin
        res.kind      = 1'b1;
        res.left_out  = a_item_r.left;
        res.right_out = a_item_r.right;
      end
    endcase
  end

  always_comb begin
    clr_nxt       = clr_r;
    clr_addr_nxt  = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(LOOP_DEPTH - 1)) clr_nxt = 1'b0;
    end
    a_valid_nxt   = q_pop || (a_valid_r && !out_load);
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_item_r <= q_item;
    end
    if (out_load) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      clr_addr_r  <= clr_addr_nxt;
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !out_load) |=> $stable(rdata_r))
    else $error("read data lost while result stage stalled");

  a_midi_no_audio: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.kind) |->
      (out_data_r.left_out == '0 && out_data_r.right_out == '0))
    else $error("forwarded MIDI result carries audio");

endmodule

>>> hw/rtl/midi_controlled_loop_sampler.sv
// ----------------------------------------------------------------------------
// midi_controlled_loop_sampler
// Stereo loop sampler steered by MIDI note-on events.
// ----------------------------------------------------------------------------
// Accepts one transaction per cycle unless held off by a full queue or a stalled
// output, and returns exactly one result for each, in order; the single port of
// the loop memory does one access per frame. After reset the loop memory is
// cleared one word per cycle, and input is held off until every word is cleared
// (configuration writes are still taken). A loop_length write reduces the
// position with a serial remainder unit, during which input is held off as
// well. Note-on events only take effect at the next sample frame.
// ----------------------------------------------------------------------------
module midi_controlled_loop_sampler #(
  parameter int LOOP_DEPTH = 262144
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcls_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcls_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = $clog2(LOOP_DEPTH);
  localparam int LW = (AW + 1 > mcls_pkg::LEN_W) ? AW + 1 : mcls_pkg::LEN_W;
  localparam int QW = AW + $bits(mcls_pkg::q_item_t);
  localparam logic [LW-1:0] DEPTH_L  = LW'(LOOP_DEPTH);
  localparam logic [LW-1:0] EFF_RST  =
    (LW'(mcls_pkg::LEN_RST) > DEPTH_L) ? DEPTH_L : LW'(mcls_pkg::LEN_RST);

  logic [mcls_pkg::LEN_W-1:0] len_r;
  logic [LW-1:0]              eff_len_r, eff_len_nxt;
  mcls_pkg::cfg_t             cfg_r;
  logic                       wr;
  logic                       len_wr;
  mcls_pkg::reg_idx_t         idx;
  logic [LW-1:0]              wlen;

  logic                 q_push, q_full, q_pop, q_empty;
  mcls_pkg::q_item_t    f_item, b_item;
  logic [AW-1:0]        f_addr, b_addr;
  mcls_pkg::bk_status_t bk;

  // ---- register port ----
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = mcls_pkg::reg_idx_t'(paddr[4:2]);
  assign len_wr = wr && (idx == mcls_pkg::REG_LOOP_LENGTH);
  assign wlen   = LW'(pwdata[mcls_pkg::LEN_W-1:0]);

  always_comb begin
    if (wlen == '0)         eff_len_nxt = LW'(1);
    else if (wlen > DEPTH_L) eff_len_nxt = DEPTH_L;
    else                    eff_len_nxt = wlen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r                <= mcls_pkg::LEN_RST;
      eff_len_r            <= EFF_RST;
      cfg_r.sync_to_host   <= 1'b0;
      cfg_r.transport_note <= mcls_pkg::TRANSPORT_RST;
      cfg_r.record_note    <= mcls_pkg::RECORD_RST;
      cfg_r.play_note      <= mcls_pkg::PLAY_RST;
      cfg_r.erase_note     <= mcls_pkg::ERASE_RST;
      cfg_r.bypass_note    <= mcls_pkg::BYPASS_RST;
    end else if (wr) begin
      unique case (idx)
        mcls_pkg::REG_LOOP_LENGTH: begin
          len_r     <= pwdata[mcls_pkg::LEN_W-1:0];
          eff_len_r <= eff_len_nxt;
        end
        mcls_pkg::REG_SYNC_TO_HOST:   cfg_r.sync_to_host   <= pwdata[0];
        mcls_pkg::REG_TRANSPORT_NOTE: cfg_r.transport_note <= pwdata[mcls_pkg::NOTE_W-1:0];
        mcls_pkg::REG_RECORD_NOTE:    cfg_r.record_note    <= pwdata[mcls_pkg::NOTE_W-1:0];
        mcls_pkg::REG_PLAY_NOTE:      cfg_r.play_note      <= pwdata[mcls_pkg::NOTE_W-1:0];
        mcls_pkg::REG_ERASE_NOTE:     cfg_r.erase_note     <= pwdata[mcls_pkg::NOTE_W-1:0];
        mcls_pkg::REG_BYPASS_NOTE:    cfg_r.bypass_note    <= pwdata[mcls_pkg::NOTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mcls_pkg::REG_LOOP_LENGTH:    prdata = 32'(len_r);
      mcls_pkg::REG_SYNC_TO_HOST:   prdata = 32'(cfg_r.sync_to_host);
      mcls_pkg::REG_TRANSPORT_NOTE: prdata = 32'(cfg_r.transport_note);
      mcls_pkg::REG_RECORD_NOTE:    prdata = 32'(cfg_r.record_note);
      mcls_pkg::REG_PLAY_NOTE:      prdata = 32'(cfg_r.play_note);
      mcls_pkg::REG_ERASE_NOTE:     prdata = 32'(cfg_r.erase_note);
      mcls_pkg::REG_BYPASS_NOTE:    prdata = 32'(cfg_r.bypass_note);
      default:                      prdata = '0;
    endcase
  end

  // ---- datapath ----
  mcls_front #(
    .AW (AW),
    .LW (LW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .eff_len  (eff_len_r),
    .len_wr   (len_wr),
    .q_full   (q_full),
    .bk       (bk),
    .q_push   (q_push),
    .q_item   (f_item),
    .q_addr   (f_addr)
  );

  mcls_fifo #(
    .W (QW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_addr, f_item}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  ({b_addr, b_item}),
    .empty     (q_empty)
  );

  mcls_back #(
    .LOOP_DEPTH (LOOP_DEPTH),
    .AW         (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (b_item),
    .q_addr    (b_addr),
    .q_pop     (q_pop),
    .bk        (bk),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> bench/midi_controlled_loop_sampler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_controlled_loop_sampler_test
// Self-checking bench for the MIDI-controlled stereo loop sampler.
// ----------------------------------------------------------------------------
// Drives MIDI and sample-frame transactions with random gaps on both sides and
// keeps a behavioral copy of the sampler: event latching, mode and free-run
// changes, loop position and loop memory. Each output transaction is compared
// field by field against the oldest predicted one. Phases cover the reset
// defaults, register extremes, record/playback over short loops, loop length
// rewrites, a long output stall and random sessions under changing settings.
// ----------------------------------------------------------------------------
module midi_controlled_loop_sampler_test;

  localparam int LOOP_WORDS   = 262144;
  localparam int CLK_PERIOD   = 20;
  localparam int DRAIN_CYCLES = 16;
  localparam int TIMEOUT_NS   = 30_000_000;
  localparam int REG_UNUSED   = 7;

  localparam logic [7:0] NOTE_ON_STATUS  = {mcls_pkg::MIDI_NOTE_ON, 4'h0};
  localparam logic [7:0] NOTE_OFF_STATUS = 8'h80;
  localparam logic [7:0] SYSEX_STATUS    = 8'hF0;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  mcls_pkg::in_item_t    in_data;
  logic                  out_valid;
  logic                  out_ready;
  mcls_pkg::out_item_t   out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [4:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  // sampler state as predicted
  logic [mcls_pkg::LEN_W-1:0]      len_reg;
  logic                            sync_reg;
  logic [mcls_pkg::NOTE_W-1:0]     trig_note [mcls_pkg::EVT_W];
  logic [mcls_pkg::EVT_W-1:0]      armed_events;
  mcls_pkg::mode_t                 play_mode;
  logic                            free_running;
  int unsigned                     loop_pos;
  logic [2*mcls_pkg::SAMPLE_W-1:0] loop_words [int unsigned];

  mcls_pkg::out_item_t due_outputs [$];
  int                  errors;
  bit                  dense;
  int                  hold_off_len;

  midi_controlled_loop_sampler #(
    .LOOP_DEPTH(LOOP_WORDS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  function automatic int idle_gap();
    int r;
    if (dense) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned active_length();
    if (len_reg == '0) return 1;
    if (len_reg > LOOP_WORDS) return LOOP_WORDS;
    return len_reg;
  endfunction

  function automatic mcls_pkg::out_item_t sampler_output(input mcls_pkg::in_item_t it);
    mcls_pkg::out_item_t        res;
    logic [mcls_pkg::EVT_W-1:0] evt;
    int                         e;
    res = '0;
    if (!it.cmd) begin
      if (it.status_byte[7:4] == mcls_pkg::MIDI_NOTE_ON) begin
        for (e = 0; e < mcls_pkg::EVT_W; e++)
          if (it.note_byte == {1'b0, trig_note[e]}) armed_events[e] = 1'b1;
      end
      res.kind        = 1'b0;
      res.midi_status = it.status_byte;
      res.midi_data1  = it.note_byte;
      res.midi_data2  = it.velocity_byte;
      return res;
    end
    evt = armed_events;
    armed_events = '0;
    if (evt[mcls_pkg::EVT_TRANSPORT]) free_running = !free_running;
    // later bits override earlier ones
    if (evt[mcls_pkg::EVT_RECORD]) play_mode = mcls_pkg::MODE_RECORD;
    if (evt[mcls_pkg::EVT_PLAY])   play_mode = mcls_pkg::MODE_PLAY;
    if (evt[mcls_pkg::EVT_ERASE])  play_mode = mcls_pkg::MODE_ERASE;
    if (evt[mcls_pkg::EVT_BYPASS]) play_mode = mcls_pkg::MODE_BYPASS;
    res.kind      = 1'b1;
    res.left_out  = it.left_in;
    res.right_out = it.right_in;
    case (play_mode)
      mcls_pkg::MODE_RECORD: loop_words[loop_pos] = {it.left_in, it.right_in};
      mcls_pkg::MODE_PLAY: begin
        if (loop_words.exists(loop_pos))
          {res.left_out, res.right_out} = loop_words[loop_pos];
        else {res.left_out, res.right_out} = '0;
      end
      mcls_pkg::MODE_ERASE: loop_words[loop_pos] = '0;
      default: ;
    endcase
    if ((sync_reg && it.host_playing) || free_running) loop_pos++;
    if (loop_pos >= active_length()) loop_pos = 0;
    return res;
  endfunction

  function automatic mcls_pkg::in_item_t random_item(input logic cmd);
    mcls_pkg::in_item_t it;
    it.cmd           = cmd;
    it.status_byte   = 8'($urandom());
    it.note_byte     = 8'($urandom());
    it.velocity_byte = 8'($urandom());
    it.left_in       = mcls_pkg::SAMPLE_W'($urandom());
    it.right_in      = mcls_pkg::SAMPLE_W'($urandom());
    it.host_playing  = 1'($urandom());
    return it;
  endfunction

  function automatic mcls_pkg::in_item_t midi_item(input logic [7:0] status, note, vel);
    mcls_pkg::in_item_t it;
    it = random_item(1'b0);
    it.status_byte   = status;
    it.note_byte     = note;
    it.velocity_byte = vel;
    return it;
  endfunction

  function automatic mcls_pkg::in_item_t frame_item(
    input logic [mcls_pkg::SAMPLE_W-1:0] l, r, input logic host);
    mcls_pkg::in_item_t it;
    it = random_item(1'b1);
    it.left_in      = l;
    it.right_in     = r;
    it.host_playing = host;
    return it;
  endfunction

  task automatic send_item(input mcls_pkg::in_item_t item);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due_outputs.push_back(sampler_output(item));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      mcls_pkg::REG_LOOP_LENGTH: begin
        len_reg  = value[mcls_pkg::LEN_W-1:0];
        loop_pos = loop_pos % active_length();
      end
      mcls_pkg::REG_SYNC_TO_HOST: sync_reg = value[0];
      mcls_pkg::REG_TRANSPORT_NOTE:
        trig_note[mcls_pkg::EVT_TRANSPORT] = value[mcls_pkg::NOTE_W-1:0];
      mcls_pkg::REG_RECORD_NOTE:
        trig_note[mcls_pkg::EVT_RECORD] = value[mcls_pkg::NOTE_W-1:0];
      mcls_pkg::REG_PLAY_NOTE:
        trig_note[mcls_pkg::EVT_PLAY] = value[mcls_pkg::NOTE_W-1:0];
      mcls_pkg::REG_ERASE_NOTE:
        trig_note[mcls_pkg::EVT_ERASE] = value[mcls_pkg::NOTE_W-1:0];
      mcls_pkg::REG_BYPASS_NOTE:
        trig_note[mcls_pkg::EVT_BYPASS] = value[mcls_pkg::NOTE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_notes(input logic [31:0] t, r, p, e, b);
    write_reg(mcls_pkg::REG_TRANSPORT_NOTE, t);
    write_reg(mcls_pkg::REG_RECORD_NOTE, r);
    write_reg(mcls_pkg::REG_PLAY_NOTE, p);
    write_reg(mcls_pkg::REG_ERASE_NOTE, e);
    write_reg(mcls_pkg::REG_BYPASS_NOTE, b);
  endtask

  task automatic write_default_notes();
    write_notes(mcls_pkg::TRANSPORT_RST, mcls_pkg::RECORD_RST, mcls_pkg::PLAY_RST,
                mcls_pkg::ERASE_RST, mcls_pkg::BYPASS_RST);
  endtask

  function automatic logic [7:0] event_note(input int e);
    return {1'b0, trig_note[e]};
  endfunction

  function automatic logic [7:0] note_on_any();
    return NOTE_ON_STATUS | 8'($urandom_range(0, 15));
  endfunction

  // note-on/frame phrases with random content, plus stray and broken messages
  task automatic run_session(input int n_items);
    int sent, r, k, e;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 99);
      e = (k < 15) ? mcls_pkg::EVT_TRANSPORT :
          (k < 45) ? mcls_pkg::EVT_RECORD :
          (k < 75) ? mcls_pkg::EVT_PLAY :
          (k < 85) ? mcls_pkg::EVT_ERASE : mcls_pkg::EVT_BYPASS;
      if (r < 55) begin
        send_item(midi_item(note_on_any(), event_note(e), 8'($urandom())));
        k = $urandom_range(1, 8);
        repeat (k) send_item(random_item(1'b1));
        sent += k + 1;
      end else if (r < 75) begin
        k = $urandom_range(1, 6);
        repeat (k) send_item(random_item(1'b1));
        sent += k;
      end else if (r < 90) begin
        send_item(random_item(1'b0));
        sent++;
      end else begin
        k = $urandom_range(0, 2);
        if (k == 0) begin
          send_item(midi_item(note_on_any(), event_note(e) | 8'h80, 8'($urandom())));
        end else if (k == 1) begin
          send_item(midi_item(NOTE_OFF_STATUS | 8'($urandom_range(0, 15)), event_note(e),
                              8'($urandom())));
        end else begin
          send_item(midi_item(note_on_any(), event_note(e), 8'($urandom())));
          send_item(midi_item(note_on_any(),
                              event_note($urandom_range(0, mcls_pkg::EVT_W - 1)),
                              8'($urandom())));
          sent++;
        end
        send_item(random_item(1'b1));
        sent += 2;
      end
    end
  endtask

  task automatic test_directed_defaults();
    mcls_pkg::in_item_t it;
    dense = 1'b1;
    send_item(frame_item(24'h7FFFFF, 24'h800000, 1'b0));
    send_item(frame_item(24'h000000, 24'hFFFFFF, 1'b1));
    send_item(midi_item(NOTE_ON_STATUS, event_note(mcls_pkg::EVT_RECORD), 8'h7F));
    send_item(frame_item(24'h123456, 24'hFFFFFB, 1'b0));
    // note-off with a matching note must not arm anything
    send_item(midi_item(NOTE_OFF_STATUS, event_note(mcls_pkg::EVT_PLAY), 8'h40));
    send_item(frame_item(24'h800000, 24'h7FFFFF, 1'b0));
    send_item(midi_item(NOTE_ON_STATUS | 8'h0F, event_note(mcls_pkg::EVT_PLAY), 8'h00));
    send_item(random_item(1'b1));
    send_item(midi_item(NOTE_ON_STATUS, event_note(mcls_pkg::EVT_PLAY) | 8'h80, 8'h55));
    send_item(midi_item(SYSEX_STATUS, event_note(mcls_pkg::EVT_ERASE), 8'h01));
    send_item(random_item(1'b1));
    send_item(midi_item(NOTE_ON_STATUS | 8'h03, event_note(mcls_pkg::EVT_ERASE), 8'h7F));
    send_item(random_item(1'b1));
    send_item(midi_item(NOTE_ON_STATUS, event_note(mcls_pkg::EVT_PLAY), 8'h20));
    send_item(random_item(1'b1));
    send_item(midi_item(NOTE_ON_STATUS, event_note(mcls_pkg::EVT_BYPASS), 8'hFF));
    send_item(random_item(1'b1));
    // several modes in one batch: the highest one wins
    send_item(midi_item(NOTE_ON_STATUS, event_note(mcls_pkg::EVT_RECORD), 8'h10));
    send_item(midi_item(NOTE_ON_STATUS, event_note(mcls_pkg::EVT_PLAY), 8'h10));
    send_item(midi_item(NOTE_ON_STATUS, event_note(mcls_pkg::EVT_ERASE), 8'h10));
    it = frame_item(24'h5A5A5A, 24'hA5A5A5, 1'b1);
    it.status_byte = NOTE_ON_STATUS;
    it.note_byte   = event_note(mcls_pkg::EVT_TRANSPORT);
    send_item(it);
    send_item(midi_item(NOTE_ON_STATUS, event_note(mcls_pkg::EVT_TRANSPORT), 8'hFF));
    send_item(midi_item(NOTE_ON_STATUS, event_note(mcls_pkg::EVT_TRANSPORT), 8'h01));
    send_item(random_item(1'b1));
    send_item(midi_item(8'hFF, 8'hFF, 8'hFF));
    send_item(midi_item(NOTE_ON_STATUS, event_note(mcls_pkg::EVT_PLAY), 8'h30));
    send_item(random_item(1'b1));
    dense = 1'b0;
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_reg(mcls_pkg::REG_LOOP_LENGTH, 32'h0);
    write_reg(mcls_pkg::REG_SYNC_TO_HOST, 32'h1);
    write_notes(32'd0, 32'd127, 32'd1, 32'd126, 32'd64);
    run_session(25);
    wait_drained();
    write_reg(mcls_pkg::REG_LOOP_LENGTH, 32'hFFFF_FFFF);
    write_reg(mcls_pkg::REG_SYNC_TO_HOST, 32'h0);
    write_notes(32'hFFFF_FFFF, 32'hFFFF_FF80, 32'd126, 32'd1, 32'd2);
    run_session(25);
    wait_drained();
    write_reg(REG_UNUSED, $urandom());
    write_reg(mcls_pkg::REG_LOOP_LENGTH, 32'd1);
    write_reg(mcls_pkg::REG_SYNC_TO_HOST, 32'hFFFF_FFFE);
    run_session(25);
    wait_drained();
  endtask

  // record one full loop, then listen to it twice
  task automatic test_loop_recall();
    write_reg(mcls_pkg::REG_LOOP_LENGTH, 32'd8);
    write_reg(mcls_pkg::REG_SYNC_TO_HOST, 32'd1);
    write_default_notes();
    if (!free_running)
      send_item(midi_item(note_on_any(), event_note(mcls_pkg::EVT_TRANSPORT), 8'h64));
    send_item(midi_item(note_on_any(), event_note(mcls_pkg::EVT_RECORD), 8'h64));
    repeat (8) send_item(random_item(1'b1));
    send_item(midi_item(note_on_any(), event_note(mcls_pkg::EVT_PLAY), 8'h64));
    repeat (16) send_item(random_item(1'b1));
    wait_drained();
    write_reg(mcls_pkg::REG_LOOP_LENGTH, $urandom_range(2, 16));
    run_session(30);
    wait_drained();
  endtask

  // move the position far, then shrink the loop under it
  task automatic test_length_rewrite();
    write_reg(mcls_pkg::REG_LOOP_LENGTH, mcls_pkg::LEN_RST);
    write_reg(mcls_pkg::REG_SYNC_TO_HOST, 32'd0);
    if (!free_running)
      send_item(midi_item(note_on_any(), event_note(mcls_pkg::EVT_TRANSPORT), 8'h64));
    send_item(midi_item(note_on_any(), event_note(mcls_pkg::EVT_RECORD), 8'h64));
    repeat ($urandom_range(30, 45)) send_item(random_item(1'b1));
    wait_drained();
    write_reg(mcls_pkg::REG_LOOP_LENGTH, $urandom_range(3, 9));
    run_session(30);
    wait_drained();
  endtask

  task automatic test_output_stall();
    write_reg(mcls_pkg::REG_LOOP_LENGTH, $urandom_range(4, 12));
    dense = 1'b1;
    hold_off_len = 300;
    run_session(60);
    dense = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_sessions();
    int s;
    for (s = 0; s < 5; s++) begin
      if ($urandom_range(0, 4) == 0)
        write_reg(mcls_pkg::REG_LOOP_LENGTH, $urandom_range(0, 19'h7FFFF));
      else write_reg(mcls_pkg::REG_LOOP_LENGTH, $urandom_range(1, 32));
      write_reg(mcls_pkg::REG_SYNC_TO_HOST, $urandom_range(0, 1));
      if (s % 2 == 1)
        write_notes($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 127), $urandom_range(0, 127));
      else
        write_default_notes();
      dense = (s == 2);
      run_session(35);
      wait_drained();
    end
    dense = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] want, got);
    if (got !== want) begin
      errors++;
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : output_check
    mcls_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (due_outputs.size() == 0) begin
        errors++;
        $display("%0t unexpected output transaction: expected none, actual kind %0d",
                 $time, out_data.kind);
      end else begin
        want = due_outputs.pop_front();
        compare_field("kind", want.kind, out_data.kind);
        compare_field("midi_status", want.midi_status, out_data.midi_status);
        compare_field("midi_data1", want.midi_data1, out_data.midi_data1);
        compare_field("midi_data2", want.midi_data2, out_data.midi_data2);
        compare_field("left_out", want.left_out, out_data.left_out);
        compare_field("right_out", want.right_out, out_data.right_out);
      end
    end
  end

  initial begin : result_sink
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_len > 0) begin
        n = hold_off_len;
        hold_off_len = 0;
      end else begin
        n = idle_gap();
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    errors   = 0;
    dense    = 1'b0;
    hold_off_len = 0;
    len_reg  = mcls_pkg::LEN_RST;
    sync_reg = 1'b0;
    trig_note[mcls_pkg::EVT_TRANSPORT] = mcls_pkg::TRANSPORT_RST;
    trig_note[mcls_pkg::EVT_RECORD]    = mcls_pkg::RECORD_RST;
    trig_note[mcls_pkg::EVT_PLAY]      = mcls_pkg::PLAY_RST;
    trig_note[mcls_pkg::EVT_ERASE]     = mcls_pkg::ERASE_RST;
    trig_note[mcls_pkg::EVT_BYPASS]    = mcls_pkg::BYPASS_RST;
    armed_events = '0;
    play_mode    = mcls_pkg::MODE_IDLE;
    free_running = 1'b0;
    loop_pos     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_defaults();
    test_register_extremes();
    test_loop_recall();
    test_length_rewrite();
    test_output_stall();
    test_random_sessions();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
